[design/lbqh_pkg.sv]
`timescale 1ns / 1ps
package lbqh_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned StepW = 19;
  localparam int unsigned BcntW = 11;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned BndW = 49;
  localparam logic [BndW-1:0] BoundCap = 49'h1_0000_0000_0000;

  localparam logic [2:0] RegLower = 3'd0;
  localparam logic [2:0] RegUpper = 3'd1;
  localparam logic [2:0] RegStep  = 3'd2;
  localparam logic [2:0] RegBcnt  = 3'd3;
  localparam logic [2:0] RegDflt  = 3'd4;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_WALK  = 7'b0001000,
    ST_RMW   = 7'b0010000,
    ST_WB    = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic         start;
    logic [BndW-1:0] b_in;
  } bstep_req_t;
endpackage

[design/lbqh_bnd_step.sv]
`timescale 1ns / 1ps
// next boundary: (b*step)>>16 saturated; two registered partial products
module lbqh_bnd_step import lbqh_pkg::*; (
  input  logic                 clk,
  input  bstep_req_t           req,
  input  logic [StepW-1:0]     step,
  output logic [BndW-1:0]      b_out
);
  logic [51:0] hi_r;
  logic [34:0] lo_r;
  logic [52:0] sum;
  always_ff @(posedge clk) begin
    if (req.start) begin
      hi_r <= 52'(req.b_in[BndW-1:16]) * 52'(step);
      lo_r <= 35'(req.b_in[15:0]) * 35'(step);
    end
  end
  assign sum = 53'(hi_r) + 53'(lo_r[34:16]);
  assign b_out = (sum > 53'(BoundCap)) ? BoundCap : sum[BndW-1:0];
endmodule

[design/log_bucket_quantile_histogram_unit.sv]
`timescale 1ns / 1ps
// Add: the boundary of each of the n active buckets is compared with the sample and then
// advanced by the step unit; then the chosen count is read and written back. Query: the
// counts are read bucket by bucket until the running sum reaches the target or the last bucket.
// Zero samples and queries on an empty store answer the next cycle. One item at a time.
// Reset: synchronous active low; then a clearing pass over every entry of the
// count memory, during which no item is accepted.
module log_bucket_quantile_histogram_unit import lbqh_pkg::*; #(
  parameter int unsigned BUCKETS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [31:0]       in_sample_value,
  input  logic [16:0]       in_alpha_fraction,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_result_value,
  output logic              out_sample_dropped,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  localparam int unsigned AW = $clog2(BUCKETS);
  localparam int unsigned KW = AW + 1;

  logic [DataW-1:0] mem [BUCKETS];
  logic [DataW-1:0] rd_r;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [DataW-1:0] wdata;

  logic [31:0] lower_r, upper_r, dflt_r;
  logic [StepW-1:0] step_r;
  logic [BcntW-1:0] bcnt_r;

  state_t state_r;
  logic [KW-1:0] k_r, n;
  logic [AW-1:0] sel_r;
  logic phase_r;
  logic [47:0] sq_r;
  logic [48:0] target_r;
  logic [48:0] sum_r;
  logic [BndW-1:0] b_r, b_nxt;
  logic [31:0] total_r;
  logic [31:0] res_r;
  logic drop_r;
  bstep_req_t breq;

  assign n = (bcnt_r == '0) ? KW'(1) :
             (32'(bcnt_r) > BUCKETS) ? KW'(BUCKETS) : KW'(bcnt_r);

  assign breq.start = 1'b1;
  assign breq.b_in = b_r;
  lbqh_bnd_step u_step (.clk(clk), .req(breq), .step(step_r), .b_out(b_nxt));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == ST_OUT);
  assign out_result_value = res_r;
  assign out_sample_dropped = drop_r;

  always_comb begin
    we = 1'b0;
    waddr = sel_r;
    wdata = rd_r;
    raddr = (state_r == ST_WALK) ? k_r[AW-1:0] : sel_r;
    if (state_r == ST_CLEAR) begin
      we = 1'b1; waddr = k_r[AW-1:0]; wdata = '0;
    end else if (state_r == ST_WB) begin
      we = 1'b1;
      wdata = (rd_r == '1) ? rd_r : rd_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= 32'd1; upper_r <= '1; step_r <= StepW'(66191);
      bcnt_r <= BcntW'(1024); dflt_r <= 32'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegLower: lower_r <= cfg_data;
        RegUpper: upper_r <= cfg_data;
        RegStep:  step_r <= cfg_data[StepW-1:0];
        RegBcnt:  bcnt_r <= cfg_data[BcntW-1:0];
        RegDflt:  dflt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; k_r <= '0; total_r <= '0; phase_r <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          k_r <= k_r + KW'(1);
          if (k_r == KW'(BUCKETS - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: if (in_valid) begin
          sq_r <= {in_sample_value, 16'd0};
          target_r <= 49'(in_alpha_fraction) * 49'(total_r);
          b_r <= {1'b0, lower_r, 16'd0};
          k_r <= '0; sel_r <= '0; sum_r <= '0; res_r <= '0; drop_r <= 1'b0;
          phase_r <= 1'b0;
          if (!in_mode && in_sample_value == '0) begin
            drop_r <= 1'b1; state_r <= ST_OUT;
          end else if (in_mode && total_r == '0) begin
            res_r <= dflt_r; state_r <= ST_OUT;
          end else state_r <= in_mode ? ST_WALK : ST_MUL;
        end
        ST_MUL: begin
          // phase 0: compare + launch multiply; phase 1: take next boundary
          if (!phase_r) begin
            if (49'(sq_r) >= b_r) sel_r <= k_r[AW-1:0];
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0; b_r <= b_nxt; k_r <= k_r + KW'(1);
            if (k_r + KW'(1) == n) state_r <= ST_RMW;
          end
        end
        ST_WALK: begin
          // phase 0: memory read of k + multiply; phase 1: decide
          if (!phase_r) phase_r <= 1'b1;
          else begin
            phase_r <= 1'b0;
            if ({sum_r, 16'd0} >= 65'(target_r)) begin
              res_r <= (b_r[48:16] > 33'hFFFF_FFFF) ? '1 : b_r[47:16];
              state_r <= ST_OUT;
            end else begin
              sum_r <= sum_r + 49'(rd_r); b_r <= b_nxt; k_r <= k_r + KW'(1);
              if (k_r + KW'(1) == n) begin
                res_r <= upper_r; state_r <= ST_OUT;
              end
            end
          end
        end
        ST_RMW: state_r <= ST_WB;
        ST_WB: begin
          if (total_r != '1) total_r <= total_r + 32'd1;
          state_r <= ST_OUT;
        end
        ST_OUT: if (out_ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value)) else $error("out held");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("overlap");
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_CLEAR |=> total_r >= $past(total_r)) else $error("total fell");
endmodule

[verif/tb_log_bucket_quantile_histogram_unit.sv]
`timescale 1ns / 1ps
module tb_log_bucket_quantile_histogram_unit;
  import lbqh_pkg::*;

  localparam int unsigned NBUCK = 1024;
  localparam logic [2:0] RegUnused = 3'd5;
  localparam int unsigned StallLimit = 30000;
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct {
    logic        mode;
    logic [31:0] sample;
    logic [16:0] alpha;
  } hist_item_t;

  typedef struct {
    logic [31:0] value;
    logic        dropped;
  } hist_res_t;

  class quantile_predictor;
    longint unsigned lower, upper, step, bcnt, dflt;
    logic [31:0] counts [NBUCK];
    logic [31:0] total;
    hist_res_t expected_results[$];
    int errors;

    function new();
      lower = 1; upper = 32'hFFFF_FFFF; step = 66191; bcnt = 1024; dflt = 1;
      foreach (counts[i]) counts[i] = '0;
      total = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        RegLower: lower = data;
        RegUpper: upper = data;
        RegStep:  step = data[18:0];
        RegBcnt:  bcnt = data[10:0];
        RegDflt:  dflt = data;
        default: ;
      endcase
    endfunction

    function longint unsigned grow(longint unsigned b);
      longint unsigned r;
      r = (b >> 16) * step + (((b & 64'hFFFF) * step) >> 16);
      return (r > (64'd1 << 48)) ? (64'd1 << 48) : r;
    endfunction

    function void note_item(logic mode, logic [31:0] sample, logic [16:0] alpha);
      longint unsigned n, b, sq, target, sum, v;
      int unsigned sel;
      hist_res_t r;
      n = (bcnt == 0) ? 1 : (bcnt > NBUCK) ? NBUCK : bcnt;
      b = lower << 16;
      r.value = '0;
      r.dropped = 1'b0;
      if (mode == MODE_ADD) begin
        if (sample == 0) begin
          r.dropped = 1'b1;
        end else begin
          sq = longint'(sample) << 16;
          sel = 0;
          for (int k = 0; k < n; k++) begin
            if (sq >= b) sel = k;
            b = grow(b);
          end
          if (counts[sel] != 32'hFFFF_FFFF) counts[sel]++;
          if (total != 32'hFFFF_FFFF) total++;
        end
      end else if (total == 0) begin
        r.value = dflt[31:0];
      end else begin
        target = longint'(alpha) * longint'(total);
        sum = 0;
        r.value = upper[31:0];
        for (int k = 0; k < n; k++) begin
          if ((sum << 16) >= target) begin
            v = b >> 16;
            r.value = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
            break;
          end
          sum += counts[k];
          b = grow(b);
        end
      end
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] value, logic dropped);
      hist_res_t e;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected item value=%0h dropped=%0b", value, dropped));
      end else begin
        e = expected_results.pop_front();
        if (value !== e.value)
          report($sformatf("result_value got %0h want %0h", value, e.value));
        if (dropped !== e.dropped)
          report($sformatf("sample_dropped got %0b want %0b", dropped, e.dropped));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = 1'b0;
  logic [31:0] in_sample_value = '0;
  logic [16:0] in_alpha_fraction = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_value;
  logic        out_sample_dropped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  quantile_predictor sb = new();
  hist_item_t pending_items[$];
  int unsigned idle_in = 0, idle_out = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_add = 0, n_query = 0, n_drop_sent = 0, n_cfg = 0;

  always #4 clk = ~clk;

  log_bucket_quantile_histogram_unit #(.BUCKETS(NBUCK)) u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_sample_value, .in_alpha_fraction,
    .out_valid, .out_ready, .out_result_value, .out_sample_dropped,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always @(posedge clk) begin : drive_items
    hist_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sb.note_item(in_mode, in_sample_value, in_alpha_fraction);
        if (in_mode == MODE_ADD) n_add++; else n_query++;
        if (in_mode == MODE_ADD && in_sample_value == 0) n_drop_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_in) begin
          it = pending_items.pop_front();
          in_mode <= it.mode;
          in_sample_value <= it.sample;
          in_alpha_fraction <= it.alpha;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_result_value, out_sample_dropped);
      out_ready <= ($urandom_range(0, 99) >= idle_out);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no item moved for %0d cycles", StallLimit);
      $display("tb_log_bucket_quantile_histogram_unit NOT OK");
      $finish;
    end
  end

  task cfg_write(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  task push_item(logic mode, logic [31:0] sample, logic [16:0] alpha);
    hist_item_t it;
    it.mode = mode;
    it.sample = sample;
    it.alpha = alpha;
    pending_items.push_back(it);
  endtask

  task drain();
    while (pending_items.size() > 0 || in_valid || sb.expected_results.size() > 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task setup(logic [31:0] lo, logic [31:0] hi, logic [31:0] stp, logic [31:0] bc,
             logic [31:0] df);
    cfg_write(RegLower, lo);
    cfg_write(RegUpper, hi);
    cfg_write(RegStep, stp);
    cfg_write(RegBcnt, bc);
    cfg_write(RegDflt, df);
  endtask

  task random_items(int unsigned count);
    logic [31:0] s;
    logic [16:0] a;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: s = '0;
        1: s = 32'hFFFF_FFFF;
        default: s = $urandom >> $urandom_range(0, 31);
      endcase
      a = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 131071))
                                      : 17'($urandom_range(0, 65536));
      push_item(($urandom_range(0, 99) < 30) ? MODE_QUERY : MODE_ADD, s, a);
    end
  endtask

  function logic [31:0] pick_step();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'd40000;
      3: return 32'h7FFFF;
      4: return 32'd262144;
      default: return $urandom_range(65537, 262144);
    endcase
  endfunction

  function logic [31:0] pick_lower();
    case ($urandom_range(0, 3))
      0: return 32'd1;
      1: return $urandom;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty store, defaults and extremes of default_value, then first adds and queries
    push_item(MODE_QUERY, $urandom, 17'd32768);
    drain();
    cfg_write(RegDflt, 32'hFFFF_FFFF);
    push_item(MODE_QUERY, '0, 17'd0);
    drain();
    cfg_write(RegDflt, 32'h0);
    cfg_write(RegUnused, 32'h1234_5678);
    push_item(MODE_QUERY, '0, 17'h1FFFF);
    push_item(MODE_ADD, 32'd0, 17'h1FFFF);
    push_item(MODE_ADD, 32'd1, '0);
    push_item(MODE_ADD, 32'hFFFF_FFFF, '0);
    push_item(MODE_ADD, 32'h0001_0000, '0);
    push_item(MODE_QUERY, '0, 17'd0);
    push_item(MODE_QUERY, '0, 17'd65536);
    push_item(MODE_QUERY, '0, 17'h1FFFF);
    push_item(MODE_QUERY, '0, 17'd32768);
    drain();

    // lower bound above every sample, tiny and oversized bucket counts
    setup(32'hFFFF_FFFF, 32'h0, 32'd262144, 32'd4, 32'd7);
    push_item(MODE_ADD, 32'd5, '0);
    push_item(MODE_ADD, 32'hFFFF_FFFF, '0);
    push_item(MODE_QUERY, '0, 17'd65536);
    push_item(MODE_QUERY, '0, 17'h1FFFF);
    drain();
    setup(32'd1, 32'hFFFF_FFFF, 32'h7FFFF, 32'd0, 32'd1);
    push_item(MODE_ADD, 32'd3, '0);
    push_item(MODE_QUERY, '0, 17'd65536);
    drain();
    cfg_write(RegBcnt, 32'h7FF);
    push_item(MODE_ADD, 32'd1000, '0);
    push_item(MODE_QUERY, '0, 17'd100);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_in = (ph < 3) ? 23 : (ph < 6) ? 74 : 0;
      idle_out = (ph < 3) ? 74 : (ph < 6) ? 23 : 0;
      setup(pick_lower(), $urandom, pick_step(),
            (ph == 7) ? 32'd1024 : $urandom_range(1, 40), $urandom);
      random_items((ph == 7) ? 20 : 80);
      drain();
    end
    idle_in = 0;
    idle_out = 0;

    repeat (2200) @(posedge clk);
    $display("covered %0d adds (%0d zero samples), %0d queries, %0d register writes",
             n_add, n_drop_sent, n_query, n_cfg);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("tb_log_bucket_quantile_histogram_unit OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_results.size());
      $display("tb_log_bucket_quantile_histogram_unit NOT OK");
    end
    $finish;
  end
endmodule
